@@ rtl/assert_macros.svh @@
// Assertion macros shared by the frame receiver modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Check that a condition implies another in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");
// Check that a condition implies another in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

@@ rtl/wfr_pkg.sv @@
// Shared types and constants of the Wiegand frame receiver.
`timescale 1ns / 1ps

package wfr_pkg;

	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 10;
	localparam int FRAME_W     = 32;

	localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HOLDOFF = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL = 2'd2;

	localparam logic [7:0] TIMEOUT_RESET = 8'd20;
	localparam logic [9:0] HOLDOFF_RESET = 10'd150;

	localparam logic FUNC_TICK   = 1'b0;
	localparam logic FUNC_STROBE = 1'b1;

	typedef struct packed {
		logic [7:0] timeout_ticks;
		logic [9:0] holdoff_ticks;
		logic       channel_id;
	} cfg_t;

	typedef struct packed {
		logic               channel;
		logic [7:0]         bit_count;
		logic [FRAME_W-1:0] frame_data;
		logic               overflow;
	} result_t;

endpackage

@@ rtl/wfr_core.sv @@
// Frame assembly: bit buffer, bit counter, silence timer and holdoff counter.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module wfr_core #(
	parameter int FRAME_BYTES = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             accept,
	input  logic             func,
	input  logic             data_bit,
	input  wfr_pkg::cfg_t    cfg,
	output logic             push,
	output wfr_pkg::result_t res
);
	import wfr_pkg::*;

	localparam int CAP_BITS = 8 * FRAME_BYTES;
	localparam int IDX_W    = $clog2(CAP_BITS);

	// buffer is kept left-aligned: the first bit lands in the top position
	logic [CAP_BITS-1:0] buf_q;
	logic [7:0]          bits_q;
	logic                ovf_q;
	logic                timer_q;
	logic [7:0]          silence_q;
	logic [9:0]          holdoff_q;

	logic               strobe;
	logic               tick;
	logic               room;
	logic [IDX_W-1:0]   wpos;
	logic [7:0]         limit;
	logic [7:0]         silence_inc;
	logic [FRAME_W-1:0] frame;

	always_comb begin
		strobe      = accept && (func == FUNC_STROBE);
		tick        = accept && (func == FUNC_TICK);
		room        = bits_q < 8'(CAP_BITS);
		wpos        = IDX_W'(CAP_BITS - 1) - bits_q[IDX_W-1:0];
		limit       = (cfg.timeout_ticks == 8'd0) ? 8'd1 : cfg.timeout_ticks;
		silence_inc = (silence_q == 8'hFF) ? silence_q : silence_q + 8'd1;
		push        = tick && timer_q && (silence_inc >= limit);
	end

	generate
		if (CAP_BITS >= FRAME_W) begin : g_wide
			assign frame = buf_q[CAP_BITS-1 -: FRAME_W];
		end else begin : g_narrow
			assign frame = {buf_q, {(FRAME_W - CAP_BITS){1'b0}}};
		end
	endgenerate

	always_comb begin
		res.channel    = cfg.channel_id;
		res.bit_count  = bits_q;
		res.frame_data = frame;
		res.overflow   = ovf_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_q     <= '0;
			bits_q    <= '0;
			ovf_q     <= 1'b0;
			timer_q   <= 1'b0;
			silence_q <= '0;
			holdoff_q <= '0;
		end else if (push) begin
			// frame ends: clear and start holdoff
			buf_q     <= '0;
			bits_q    <= '0;
			ovf_q     <= 1'b0;
			timer_q   <= 1'b0;
			silence_q <= '0;
			holdoff_q <= cfg.holdoff_ticks;
		end else if (strobe && (holdoff_q == 10'd0)) begin
			if (room) begin
				buf_q[wpos] <= data_bit;
			end else begin
				ovf_q <= 1'b1;
			end
			if (bits_q != 8'hFF) begin
				bits_q <= bits_q + 8'd1;
			end
			timer_q   <= 1'b1;
			silence_q <= '0;
		end else if (tick) begin
			if (timer_q) begin
				silence_q <= silence_inc;
			end else if (holdoff_q != 10'd0) begin
				holdoff_q <= holdoff_q - 10'd1;
			end
		end
	end

	`ASSERT_IMPLIES(a_holdoff_idle, clk, arst_n, holdoff_q != 10'd0, !timer_q)
	`ASSERT_IMPLIES(a_timer_has_bits, clk, arst_n, timer_q, bits_q != 8'd0)
	`ASSERT_IMPLIES(a_ovf_full, clk, arst_n, ovf_q, !room)

endmodule

@@ rtl/wfr_obuf.sv @@
// Two-entry result buffer: output register plus skid register.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module wfr_obuf (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  wfr_pkg::result_t push_data,
	input  logic             out_stall,
	output logic             out_valid,
	output wfr_pkg::result_t out_data,
	output logic             full
);
	import wfr_pkg::*;

	logic    head_valid_q;
	result_t head_q;
	logic    skid_valid_q;
	result_t skid_q;
	logic    pop;

	assign pop       = head_valid_q && !out_stall;
	assign out_valid = head_valid_q;
	assign out_data  = head_q;
	assign full      = skid_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (pop) begin
			if (skid_valid_q) begin
				head_valid_q <= 1'b1;
				skid_valid_q <= push;
			end else begin
				head_valid_q <= push;
			end
		end else if (!head_valid_q) begin
			head_valid_q <= push;
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (skid_valid_q) begin
				head_q <= skid_q;
				if (push) begin
					skid_q <= push_data;
				end
			end else if (push) begin
				head_q <= push_data;
			end
		end else if (!head_valid_q) begin
			if (push) begin
				head_q <= push_data;
			end
		end else if (push) begin
			skid_q <= push_data;
		end
	end

	`ASSERT_IMPLIES(a_no_overrun, clk, arst_n, push && skid_valid_q, pop)
	`ASSERT_IMPLIES(a_skid_behind_head, clk, arst_n, skid_valid_q, head_valid_q)
	`ASSERT_NEXT(a_push_lands, clk, arst_n, push && !head_valid_q, head_valid_q)

endmodule

@@ rtl/wiegand_frame_receiver.sv @@
// Top level of the Wiegand frame receiver: configuration registers and glue.
`timescale 1ns / 1ps

// Wiegand frame receiver. Each input transfer is either a time tick
// (func = 0) or a bit strobe (func = 1) carrying the data line level.
// A strobe stores its bit, counts it and restarts the silence timer; once
// timeout_ticks ticks pass with no strobe the tick that ends the frame
// produces one output transfer with the bits left-aligned in frame_data
// (first bit at bit 31, zero padded), the saturating bit count, the channel
// and an overflow flag for bits past the 8*FRAME_BYTES bit buffer. Strobes
// are then ignored for holdoff_ticks ticks. Throughput is one input transfer
// per clock while in_stall is low: every item updates the frame state, and a
// finished frame goes into a two-entry output buffer (output register plus
// skid register) so input keeps flowing while a result waits. in_stall is
// raised only while both entries hold frames. Configuration writes
// (0 timeout_ticks, 1 holdoff_ticks, 2 channel_id) take effect on the next
// item; write them only while the block is idle. No clearing pass after reset.
module wiegand_frame_receiver #(
	parameter int FRAME_BYTES = 4
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           func,
	input  logic                           data_bit,
	input  logic                           cfg_we,
	input  logic [wfr_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [wfr_pkg::CFG_DATA_W-1:0] cfg_data,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic                           channel,
	output logic [7:0]                     bit_count,
	output logic [wfr_pkg::FRAME_W-1:0]    frame_data,
	output logic                           overflow
);
	import wfr_pkg::*;

	cfg_t    cfg_q;
	logic    accept;
	logic    push;
	result_t res;
	result_t out_data;
	logic    full;

	// Configuration registers; writes to unused indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.timeout_ticks <= TIMEOUT_RESET;
			cfg_q.holdoff_ticks <= HOLDOFF_RESET;
			cfg_q.channel_id    <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_TIMEOUT: cfg_q.timeout_ticks <= cfg_data[7:0];
				CFG_HOLDOFF: cfg_q.holdoff_ticks <= cfg_data[9:0];
				CFG_CHANNEL: cfg_q.channel_id    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Hold input only when the skid entry is occupied.
	assign in_stall = full;
	assign accept   = in_valid && !in_stall;

	wfr_core #(
		.FRAME_BYTES(FRAME_BYTES)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.func     (func),
		.data_bit (data_bit),
		.cfg      (cfg_q),
		.push     (push),
		.res      (res)
	);

	wfr_obuf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (res),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_data  (out_data),
		.full      (full)
	);

	assign channel    = out_data.channel;
	assign bit_count  = out_data.bit_count;
	assign frame_data = out_data.frame_data;
	assign overflow   = out_data.overflow;

endmodule

@@ bench/tb_wiegand_frame_receiver.sv @@
// Self-checking bench for the Wiegand frame receiver: directed table, then random frames.
`timescale 1ns / 1ps

module tb_wiegand_frame_receiver;
	import wfr_pkg::*;

	localparam int FRAME_BYTES = 4;
	localparam int CAP_BITS    = FRAME_BYTES * 8;
	// Spare register index: the block has no register there, a write must change nothing.
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
	// Cycles to let pass after the last frame before touching the registers.
	localparam int SETTLE      = 4;
	localparam int RAND_ITEMS  = 720;
	localparam int PHASE_ITEMS = 120;
	localparam int IDLE_PCT    = 18;
	localparam int CYCLE_LIMIT = 200000;

	typedef enum logic {ROW_ITEM, ROW_WRITE} row_kind_t;

	// One row of the directed table: an item repeated reps times, or a register write.
	// Rows with fixed set carry the frame that must come out, typed in by hand.
	typedef struct {
		row_kind_t               kind;
		logic                    func;
		logic                    bitv;
		int unsigned             reps;
		logic [CFG_IDX_W-1:0]    idx;
		logic [CFG_DATA_W-1:0]   val;
		bit                      fixed;
		result_t                 want;
	} row_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic                  func = FUNC_TICK;
	logic                  data_bit = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_idx = CFG_TIMEOUT;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic                  channel;
	logic [7:0]            bit_count;
	logic [FRAME_W-1:0]    frame_data;
	logic                  overflow;

	// Predicted state of the receiver and its register copies.
	logic [63:0] frame_shift;
	logic [7:0]  frame_bits;
	logic        frame_ovf;
	logic        silence_on;
	logic [7:0]  silence_ticks;
	logic [9:0]  holdoff_left;
	logic [7:0]  set_timeout;
	logic [9:0]  set_holdoff;
	logic        set_channel;

	// Frames the receiver still owes us, oldest first.
	result_t     frames_due[$];
	result_t     head_frame;

	row_t        plan[$];
	bit          calm = 1'b0;
	int unsigned cycles = 0;
	int unsigned fault_count = 0;
	int unsigned transfers = 0;
	int unsigned ignored_strobes = 0;
	int unsigned directed_items = 0;
	int unsigned rand_items = 0;
	int unsigned frames_seen = 0;
	int unsigned overflow_frames = 0;
	int unsigned saturated_frames = 0;
	int unsigned phases = 0;
	int unsigned want_bits = 0;
	int unsigned strobes_in_frame = 0;

	wiegand_frame_receiver #(
		.FRAME_BYTES(FRAME_BYTES)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.func      (func),
		.data_bit  (data_bit),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_data  (cfg_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.channel   (channel),
		.bit_count (bit_count),
		.frame_data(frame_data),
		.overflow  (overflow)
	);

	always #5 clk = ~clk;

	// Watchdog: end the run if the receiver stops moving.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("watchdog expired after %0d cycles, %0d frames outstanding",
				cycles, frames_due.size());
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// Count a failure; print only the first few in full.
	task automatic flag_fault(input string what);
		fault_count++;
		if (fault_count <= 10)
			$display("[%0t] %s", $realtime, what);
	endtask

	// Advance the predicted receiver by one accepted item; return 1 when it closes a frame.
	function automatic bit wiegand_advance(input logic f, input logic b,
			output result_t res);
		int          keep;
		logic [63:0] aligned;
		res = '0;
		if (f == FUNC_STROBE) begin
			// Drop strobes entirely during holdoff.
			if (holdoff_left != 0)
				return 1'b0;
			if (frame_bits < CAP_BITS)
				frame_shift = {frame_shift[62:0], b};
			else
				frame_ovf = 1'b1;
			if (frame_bits != 8'hFF)
				frame_bits++;
			silence_on = 1'b1;
			silence_ticks = '0;
			return 1'b0;
		end
		if (silence_on) begin
			if (silence_ticks != 8'hFF)
				silence_ticks++;
			// A zero timeout behaves as one tick.
			if (silence_ticks >= ((set_timeout == 8'd0) ? 8'd1 : set_timeout)) begin
				keep = (frame_bits > CAP_BITS) ? CAP_BITS : int'(frame_bits);
				aligned = frame_shift << (64 - keep);
				res.channel    = set_channel;
				res.bit_count  = frame_bits;
				res.frame_data = aligned[63:32];
				res.overflow   = frame_ovf;
				frame_shift   = '0;
				frame_bits    = '0;
				frame_ovf     = 1'b0;
				silence_on    = 1'b0;
				silence_ticks = '0;
				holdoff_left  = set_holdoff;
				return 1'b1;
			end
			return 1'b0;
		end
		// Idle tick: only the holdoff counts down.
		if (holdoff_left != 0)
			holdoff_left--;
		return 1'b0;
	endfunction

	// Offer one item, hold it through stalls, and record what it should cause.
	task automatic send_item(input logic f, input logic b, input bit fixed, input result_t want);
		result_t made;
		bit      closes;
		while (!calm && $urandom_range(99) < IDLE_PCT) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		func = f;
		data_bit = b;
		do
			@(posedge clk);
		while (in_stall);
		// Transfer taken at this edge.
		if (f == FUNC_STROBE && holdoff_left != 0)
			ignored_strobes++;
		closes = wiegand_advance(f, b, made);
		if (fixed)
			frames_due.push_back(want);
		else if (closes)
			frames_due.push_back(made);
		transfers++;
		@(negedge clk);
	endtask

	// Write one register once the receiver has nothing left to hand over.
	task automatic program_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		in_valid = 1'b0;
		while (frames_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_idx = idx;
		cfg_data = val;
		@(posedge clk);
		case (idx)
			CFG_TIMEOUT: set_timeout = val[7:0];
			CFG_HOLDOFF: set_holdoff = val[9:0];
			CFG_CHANNEL: set_channel = val[0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// Pick the next random item from where the predicted receiver stands.
	task automatic random_item();
		logic f;
		int   pick;
		int   limit;
		limit = (set_timeout == 8'd0) ? 1 : int'(set_timeout);
		if (holdoff_left != 0) begin
			// Mostly let the holdoff run out, with some strobes that must be dropped.
			f = ($urandom_range(99) < 90) ? FUNC_TICK : FUNC_STROBE;
		end else if (!silence_on) begin
			// Start a new frame; mostly common card lengths, now and then a huge one.
			strobes_in_frame = 0;
			pick = $urandom_range(99);
			if (pick < 35)
				want_bits = 26;
			else if (pick < 55)
				want_bits = 34;
			else if (pick < 60)
				want_bits = 32;
			else if (pick < 63)
				want_bits = $urandom_range(300, 200);
			else
				want_bits = $urandom_range(40, 1);
			f = ($urandom_range(99) < 10) ? FUNC_TICK : FUNC_STROBE;
		end else if (strobes_in_frame < want_bits) begin
			// Mid-frame: a tick that keeps the frame alive, or rarely one that may cut it short.
			if ($urandom_range(99) < 3)
				f = FUNC_TICK;
			else if ($urandom_range(99) < 15 && int'(silence_ticks) + 1 < limit)
				f = FUNC_TICK;
			else
				f = FUNC_STROBE;
		end else begin
			f = FUNC_TICK;
		end
		if (f == FUNC_STROBE && holdoff_left == 0)
			strobes_in_frame++;
		if (!(f == FUNC_STROBE && holdoff_left != 0))
			rand_items++;
		send_item(f, 1'($urandom), 1'b0, '0);
	endtask

	function automatic row_t item_row(input logic f, input logic b, input int unsigned reps);
		row_t r;
		r = '{kind: ROW_ITEM, func: f, bitv: b, reps: reps, idx: CFG_TIMEOUT, val: '0,
			fixed: 1'b0, want: '0};
		return r;
	endfunction

	function automatic row_t write_row(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		row_t r;
		r = '{kind: ROW_WRITE, func: FUNC_TICK, bitv: 1'b0, reps: 0, idx: idx, val: val,
			fixed: 1'b0, want: '0};
		return r;
	endfunction

	// A single tick that must close a frame with the given contents.
	function automatic row_t close_row(input logic ch, input logic [7:0] cnt,
			input logic [FRAME_W-1:0] bits, input logic ovf);
		row_t r;
		r = '{kind: ROW_ITEM, func: FUNC_TICK, bitv: 1'b0, reps: 1, idx: CFG_TIMEOUT,
			val: '0, fixed: 1'b1, want: '{channel: ch, bit_count: cnt, frame_data: bits,
			overflow: ovf}};
		return r;
	endfunction

	// Output side: stall at random, compare every frame taken against the oldest one owed.
	always @(negedge clk)
		out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			frames_seen++;
			if (frames_due.size() == 0) begin
				flag_fault($sformatf("unexpected frame ch=%0d cnt=%0d data=%h ovf=%0d",
					channel, bit_count, frame_data, overflow));
			end else begin
				head_frame = frames_due.pop_front();
				if (head_frame.overflow)
					overflow_frames++;
				if (head_frame.bit_count == 8'hFF)
					saturated_frames++;
				if (channel !== head_frame.channel || bit_count !== head_frame.bit_count ||
						frame_data !== head_frame.frame_data ||
						overflow !== head_frame.overflow)
					flag_fault($sformatf({"frame %0d: expected ch=%0d cnt=%0d data=%h ovf=%0d,",
						" got ch=%0d cnt=%0d data=%h ovf=%0d"}, frames_seen,
						head_frame.channel, head_frame.bit_count, head_frame.frame_data,
						head_frame.overflow, channel, bit_count, frame_data, overflow));
			end
		end
	end

	initial begin
		int unsigned budget;
		int unsigned drain;
		result_t     left_frame;
		// Hold the receiver in reset, with the predictor at its reset state.
		frame_shift   = '0;
		frame_bits    = '0;
		frame_ovf     = 1'b0;
		silence_on    = 1'b0;
		silence_ticks = '0;
		holdoff_left  = '0;
		set_timeout   = TIMEOUT_RESET;
		set_holdoff   = HOLDOFF_RESET;
		set_channel   = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed table. Start on the reset timeout and channel, then lower the timeout under the
		// silence already seen, check dropped strobes in holdoff, a zero timeout,
		// a full buffer, overflow and count saturation.
		plan = '{
			write_row(CFG_HOLDOFF, 10'd2),
			item_row(FUNC_TICK, 1'b0, 1),
			item_row(FUNC_STROBE, 1'b1, 1),
			item_row(FUNC_STROBE, 1'b0, 1),
			item_row(FUNC_TICK, 1'b0, 2),
			write_row(CFG_TIMEOUT, 10'd1),
			close_row(1'b0, 8'd2, 32'h8000_0000, 1'b0),
			item_row(FUNC_STROBE, 1'b1, 1),
			item_row(FUNC_TICK, 1'b0, 2),
			write_row(CFG_CHANNEL, 10'd1),
			write_row(CFG_TIMEOUT, 10'd0),
			write_row(CFG_HOLDOFF, 10'd0),
			item_row(FUNC_STROBE, 1'b0, 1),
			item_row(FUNC_STROBE, 1'b1, 1),
			close_row(1'b1, 8'd2, 32'h4000_0000, 1'b0),
			item_row(FUNC_STROBE, 1'b1, 32),
			close_row(1'b1, 8'd32, 32'hFFFF_FFFF, 1'b0),
			item_row(FUNC_STROBE, 1'b0, 32),
			item_row(FUNC_STROBE, 1'b1, 1),
			close_row(1'b1, 8'd33, 32'h0000_0000, 1'b1),
			item_row(FUNC_STROBE, 1'b1, 300),
			close_row(1'b1, 8'd255, 32'hFFFF_FFFF, 1'b1)
		};
		foreach (plan[r]) begin
			if (plan[r].kind == ROW_WRITE) begin
				program_reg(plan[r].idx, plan[r].val);
			end else begin
				for (int k = 0; k < int'(plan[r].reps); k++)
					send_item(plan[r].func, plan[r].bitv, plan[r].fixed, plan[r].want);
			end
		end
		directed_items = transfers;

		// Random phases: new settings each phase, written once the receiver is drained.
		// Phase 2 takes the upper extremes, phase 5 the lower ones; phases 3 and 4 run
		// with no idling on either side.
		while (rand_items < RAND_ITEMS) begin
			calm = 1'b0;
			if (phases == 2) begin
				program_reg(CFG_TIMEOUT, 10'h3FF);
				program_reg(CFG_HOLDOFF, 10'd1023);
				program_reg(CFG_CHANNEL, 10'h3FF);
			end else if (phases == 5) begin
				program_reg(CFG_TIMEOUT, 10'd1);
				program_reg(CFG_HOLDOFF, 10'd0);
				program_reg(CFG_CHANNEL, 10'h3FE);
			end else begin
				program_reg(CFG_TIMEOUT, {2'($urandom),
					($urandom_range(9) == 0) ? 8'd0 : 8'($urandom_range(6, 1))});
				program_reg(CFG_HOLDOFF, 10'($urandom_range(12)));
				program_reg(CFG_CHANNEL, 10'($urandom));
				if ($urandom_range(3) == 0)
					program_reg(CFG_SPARE, 10'($urandom));
			end
			calm = (phases == 3 || phases == 4);
			budget = rand_items + PHASE_ITEMS;
			while (rand_items < budget)
				random_item();
			phases++;
		end
		calm = 1'b0;
		in_valid = 1'b0;

		// Drain, then give the receiver time to show any stray frame.
		drain = 0;
		while (frames_due.size() != 0 && drain < 20000) begin
			@(posedge clk);
			drain++;
		end
		repeat (16) @(posedge clk);
		while (frames_due.size() != 0) begin
			left_frame = frames_due.pop_front();
			flag_fault($sformatf("frame never delivered: ch=%0d cnt=%0d data=%h ovf=%0d",
				left_frame.channel, left_frame.bit_count, left_frame.frame_data,
				left_frame.overflow));
		end

		$display("covered %0d transfers (%0d from the table, %0d strobes dropped in holdoff),",
			transfers, directed_items, ignored_strobes);
		$display("%0d random phases; checked %0d frames, %0d with overflow, %0d saturated",
			phases, frames_seen, overflow_frames, saturated_frames);
		if (fault_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

@@ files.f @@
+incdir+rtl
rtl/wfr_pkg.sv
rtl/wfr_core.sv
rtl/wfr_obuf.sv
rtl/wiegand_frame_receiver.sv
bench/tb_wiegand_frame_receiver.sv
